### sv/bank_switched_ram_core_assert.svh
// ============================================================================
// Bank-switched RAM assertion macros
// Shared clocked assertion forms used by the port checker.
// ============================================================================
`ifndef BANK_SWITCHED_RAM_CORE_ASSERT_SVH
`define BANK_SWITCHED_RAM_CORE_ASSERT_SVH

// Overlapping implication, checked on the rising edge outside reset.
`define BSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bsr_pkg.sv
// ============================================================================
// Bank-switched RAM package
// Field widths, operation codes and sequencer types shared by the core.
// ============================================================================
`default_nettype none

package bsr_pkg;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int OFS_W  = 17;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_MAP   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SEQ_CLEAR = 2'd0,
        SEQ_IDLE  = 2'd1,
        SEQ_MAP   = 2'd2
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic tbl_we;
    } seq_ctrl_t;

endpackage

`default_nettype wire

### sv/bank_switched_ram_core.sv
// ============================================================================
// Bank-switched RAM core
// Byte RAM of 2^MEM_BITS bytes reached through a table of signed per-block
// offsets, with read, write and block-range map commands.
// ============================================================================
// Read and write words are accepted one per cycle while busy is low. A read
// returns its byte on read_data with read_valid high for one cycle, after
// the offset table lookup and the data memory access; the receiver cannot
// hold it off, so it must take the byte in that cycle. Both steps are
// registered, each a synchronous memory read. A map word raises busy while
// the sequencer writes the blocks of its range into the offset table one
// after another, since the offset table has a single write port; a range
// whose start block is above its end block costs nothing. After reset,
// busy stays high while the offset table is cleared to zero.
`default_nettype none

module bank_switched_ram_core #(
    parameter int MEM_BITS   = 16,
    parameter int BLOCK_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        op,
    input  wire logic [bsr_pkg::ADDR_W-1:0]        address,
    input  wire logic [bsr_pkg::DATA_W-1:0]        write_data,
    input  wire logic [bsr_pkg::ADDR_W-1:0]        map_start,
    input  wire logic [bsr_pkg::ADDR_W-1:0]        map_end,
    input  wire logic signed [bsr_pkg::OFS_W-1:0]  map_offset,
    output logic                                   read_valid,
    output logic      [bsr_pkg::DATA_W-1:0]        read_data
);

    localparam int TABLE_BITS = (MEM_BITS > BLOCK_BITS) ? (MEM_BITS - BLOCK_BITS) : 0;
    localparam int IDX_W      = (TABLE_BITS > 0) ? TABLE_BITS : 1;
    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int AW         = (MEM_BITS > bsr_pkg::ADDR_W) ? MEM_BITS : bsr_pkg::ADDR_W;
    localparam int SUM_W      = (MEM_BITS > bsr_pkg::OFS_W) ? MEM_BITS : bsr_pkg::OFS_W;

    function automatic logic [IDX_W-1:0] block_idx(input logic [AW-1:0] a);
        logic [AW-1:0] s;
        s = a >> BLOCK_BITS;
        return (TABLE_BITS == 0) ? '0 : s[IDX_W-1:0];
    endfunction

    bsr_pkg::seq_ctrl_t            seq_ctrl;
    logic [IDX_W-1:0]              tbl_waddr;
    logic [bsr_pkg::OFS_W-1:0]     tbl_wdata;
    logic [bsr_pkg::OFS_W-1:0]     tbl_rdata;
    logic [IDX_W-1:0]              tbl_raddr;

    logic                          accept;
    logic                          is_rw;
    logic                          map_go;
    logic [AW-1:0]                 addr_ext;

    logic                          s1_valid_reg;
    logic                          s1_write_reg;
    logic [MEM_BITS-1:0]           s1_addr_reg;
    logic [bsr_pkg::DATA_W-1:0]    s1_wdata_reg;
    logic                          rv_reg;

    logic [SUM_W-1:0]              phys_sum;
    logic [MEM_BITS-1:0]           phys;
    logic                          data_we;

    assign busy     = seq_ctrl.busy;
    assign accept   = start && !busy;
    assign is_rw    = (op == bsr_pkg::OP_READ) || (op == bsr_pkg::OP_WRITE);
    assign map_go   = accept && (op == bsr_pkg::OP_MAP);
    assign addr_ext = AW'(address);
    assign tbl_raddr = block_idx(addr_ext);

    bsr_map_seq #(
        .TABLE_BITS (TABLE_BITS),
        .IDX_W      (IDX_W)
    ) u_map_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .map_go    (map_go),
        .first_idx (block_idx(AW'(map_start))),
        .last_idx  (block_idx(AW'(map_end))),
        .ofs       (map_offset),
        .ctrl      (seq_ctrl),
        .waddr     (tbl_waddr),
        .wdata     (tbl_wdata)
    );

    bsr_ram #(
        .ADDR_BITS (IDX_W),
        .DEPTH     (TABLE_SIZE),
        .WIDTH     (bsr_pkg::OFS_W)
    ) u_offset_table (
        .clk   (clk),
        .we    (seq_ctrl.tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && is_rw;
            rv_reg       <= s1_valid_reg && !s1_write_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_write_reg <= (op == bsr_pkg::OP_WRITE);
            s1_addr_reg  <= addr_ext[MEM_BITS-1:0];
            s1_wdata_reg <= write_data;
        end
    end

    assign phys_sum = SUM_W'(s1_addr_reg) + SUM_W'($signed(tbl_rdata));
    assign phys     = phys_sum[MEM_BITS-1:0];
    assign data_we  = s1_valid_reg && s1_write_reg;

    bsr_ram #(
        .ADDR_BITS (MEM_BITS),
        .DEPTH     (1 << MEM_BITS),
        .WIDTH     (bsr_pkg::DATA_W)
    ) u_data_store (
        .clk   (clk),
        .we    (data_we),
        .waddr (phys),
        .wdata (s1_wdata_reg),
        .raddr (phys),
        .rdata (read_data)
    );

    assign read_valid = rv_reg;

endmodule

`default_nettype wire

### sv/bsr_ram.sv
// ============================================================================
// Bank-switched RAM storage array
// Synchronous single-write, single-read memory with a registered read word.
// ============================================================================
`default_nettype none

module bsr_ram #(
    parameter int ADDR_BITS = 4,
    parameter int DEPTH     = 16,
    parameter int WIDTH     = 8
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/bsr_map_seq.sv
// ============================================================================
// Bank-switched RAM map sequencer
// Clears the offset table after reset and walks block ranges for map words,
// writing one table entry per cycle.
// ============================================================================
`default_nettype none

module bsr_map_seq #(
    parameter int TABLE_BITS = 4,
    parameter int IDX_W      = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         map_go,
    input  wire logic [IDX_W-1:0]             first_idx,
    input  wire logic [IDX_W-1:0]             last_idx,
    input  wire logic [bsr_pkg::OFS_W-1:0]    ofs,
    output bsr_pkg::seq_ctrl_t                ctrl,
    output logic      [IDX_W-1:0]             waddr,
    output logic      [bsr_pkg::OFS_W-1:0]    wdata
);

    localparam logic [IDX_W-1:0] TABLE_LAST = IDX_W'((1 << TABLE_BITS) - 1);

    bsr_pkg::seq_state_t           state_reg;
    bsr_pkg::seq_state_t           state_next;
    logic [IDX_W-1:0]              cnt_reg;
    logic [IDX_W-1:0]              cnt_next;
    logic [IDX_W-1:0]              last_reg;
    logic [bsr_pkg::OFS_W-1:0]     ofs_reg;
    logic                          load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsr_pkg::SEQ_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= last_idx;
            ofs_reg  <= ofs;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        load        = 1'b0;
        ctrl.busy   = 1'b1;
        ctrl.tbl_we = 1'b0;
        waddr       = cnt_reg;
        wdata       = '0;
        unique case (state_reg)
            bsr_pkg::SEQ_CLEAR:
            begin
                ctrl.tbl_we = 1'b1;
                if (cnt_reg == TABLE_LAST)
                begin
                    state_next = bsr_pkg::SEQ_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bsr_pkg::SEQ_IDLE:
            begin
                ctrl.busy = 1'b0;
                if (map_go && (first_idx <= last_idx))
                begin
                    state_next = bsr_pkg::SEQ_MAP;
                    cnt_next   = first_idx;
                    load       = 1'b1;
                end
            end
            bsr_pkg::SEQ_MAP:
            begin
                ctrl.tbl_we = 1'b1;
                wdata       = ofs_reg;
                if (cnt_reg == last_reg)
                begin
                    state_next = bsr_pkg::SEQ_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = bsr_pkg::SEQ_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/bsr_checker.sv
// ============================================================================
// Bank-switched RAM port checker
// Watches the command and result ports for latency and busy behavior.
// ============================================================================
`default_nettype none

`include "bank_switched_ram_core_assert.svh"

module bsr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] op,
    input wire logic       read_valid
);

    logic rd_acc;
    logic other_acc;

    assign rd_acc    = start && !busy && (op == bsr_pkg::OP_READ);
    assign other_acc = start && !busy && (op != bsr_pkg::OP_MAP);

    // Every accepted read produces its byte on read_valid.
    `BSR_ASSERT_SAME(a_read_latency, clk, rst_n, rd_acc, ##2 read_valid, "read result missing")
    // A result strobe is always owed to an earlier accepted read.
    `BSR_ASSERT_SAME(a_no_spurious, clk, rst_n, read_valid, $past(rd_acc, 2), "unexpected read result")
    // The offset table clear keeps the block busy right after reset.
    `BSR_ASSERT_SAME(a_clear_busy, clk, rst_n, !$past(rst_n), busy, "not busy after reset")
    // Only a map word can make the block busy.
    `BSR_ASSERT_NEXT(a_rw_no_busy, clk, rst_n, other_acc, !busy, "busy after non-map word")

endmodule

bind bank_switched_ram_core bsr_checker u_bsr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .read_valid (read_valid)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Bank-switched RAM core testbench
// Sends read, write, map and unused-op words through the start/busy handshake and
// checks every returned byte against a shadow copy of the offset table and
// the RAM, or against the byte that a directed row names. A directed table
// comes first, then random traffic with reads aimed only at written bytes.
// ============================================================================

module tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_WORDS = 1325;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RECENT_DEPTH = 256;
    localparam int NUM_BLOCKS   = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                 op;
        logic [bsr_pkg::ADDR_W-1:0] address;
        logic [bsr_pkg::DATA_W-1:0] write_data;
        logic [bsr_pkg::ADDR_W-1:0] map_start;
        logic [bsr_pkg::ADDR_W-1:0] map_end;
        logic [bsr_pkg::OFS_W-1:0]  map_offset;
        logic                       typed;
        logic [bsr_pkg::DATA_W-1:0] typed_byte;
    } ram_word_t;

    logic                              clk;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [1:0]                        op = bsr_pkg::OP_READ;
    logic [bsr_pkg::ADDR_W-1:0]        address = '0;
    logic [bsr_pkg::DATA_W-1:0]        write_data = '0;
    logic [bsr_pkg::ADDR_W-1:0]        map_start = '0;
    logic [bsr_pkg::ADDR_W-1:0]        map_end = '0;
    logic signed [bsr_pkg::OFS_W-1:0]  map_offset = '0;
    logic                              read_valid;
    logic [bsr_pkg::DATA_W-1:0]        read_data;

    logic [bsr_pkg::OFS_W-1:0]  shadow_ofs [0:NUM_BLOCKS-1];
    logic [bsr_pkg::DATA_W-1:0] shadow_ram [0:65535];
    logic [bsr_pkg::ADDR_W-1:0] recent_phys [$];
    logic [bsr_pkg::DATA_W-1:0] pending_reads [$];
    ram_word_t                  directed_words [$];
    logic [bsr_pkg::DATA_W-1:0] expected_byte;

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned n_reads = 0;
    int unsigned n_writes = 0;
    int unsigned n_maps = 0;
    int unsigned n_empty_maps = 0;
    int unsigned n_unused = 0;
    int unsigned n_checked = 0;

    bank_switched_ram_core #(
        .MEM_BITS   (16),
        .BLOCK_BITS (12)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .address    (address),
        .write_data (write_data),
        .map_start  (map_start),
        .map_end    (map_end),
        .map_offset (map_offset),
        .read_valid (read_valid),
        .read_data  (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [bsr_pkg::ADDR_W-1:0] phys_of(
        input logic [bsr_pkg::ADDR_W-1:0] bus);
        return bus + shadow_ofs[bus[15:12]][15:0];
    endfunction

    function automatic ram_word_t word_row(input logic [1:0] op_c,
                                           input logic [bsr_pkg::ADDR_W-1:0] addr_c,
                                           input logic [bsr_pkg::DATA_W-1:0] data_c,
                                           input logic [bsr_pkg::ADDR_W-1:0] first_c,
                                           input logic [bsr_pkg::ADDR_W-1:0] last_c,
                                           input logic [bsr_pkg::OFS_W-1:0] ofs_c,
                                           input logic typed_c,
                                           input logic [bsr_pkg::DATA_W-1:0] typed_byte_c);
        ram_word_t w;
        w.op = op_c;
        w.address = addr_c;
        w.write_data = data_c;
        w.map_start = first_c;
        w.map_end = last_c;
        w.map_offset = ofs_c;
        w.typed = typed_c;
        w.typed_byte = typed_byte_c;
        return w;
    endfunction

    task automatic add_row(input ram_word_t w);
        directed_words = {directed_words, w};
    endtask

    // Updates the shadow state for one accepted word and queues the byte a read returns.
    task automatic apply_word(input ram_word_t w);
        logic [bsr_pkg::ADDR_W-1:0] phys;
        int first_blk;
        int last_blk;
        case (w.op)
            bsr_pkg::OP_READ:
            begin
                phys = phys_of(w.address);
                pending_reads = {pending_reads, (w.typed ? w.typed_byte : shadow_ram[phys])};
                n_reads++;
            end
            bsr_pkg::OP_WRITE:
            begin
                phys = phys_of(w.address);
                shadow_ram[phys] = w.write_data;
                recent_phys = {recent_phys, phys};
                if (recent_phys.size() > RECENT_DEPTH)
                    void'(recent_phys.pop_front());
                n_writes++;
            end
            bsr_pkg::OP_MAP:
            begin
                first_blk = int'(w.map_start[15:12]);
                last_blk = int'(w.map_end[15:12]);
                if (first_blk <= last_blk)
                begin
                    for (int b = first_blk; b <= last_blk; b++)
                        shadow_ofs[b] = w.map_offset;
                end
                else
                    n_empty_maps++;
                n_maps++;
            end
            default:
                n_unused++;
        endcase
    endtask

    task automatic send_word(input ram_word_t w);
        op <= w.op;
        address <= w.address;
        write_data <= w.write_data;
        map_start <= w.map_start;
        map_end <= w.map_end;
        map_offset <= w.map_offset;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_word(w);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Reads are aimed at bytes already written, through any block whose offset reaches them.
    task automatic make_random_word(output ram_word_t w);
        int unsigned kind;
        int ofs_val;
        logic [31:0] rnd;
        logic [bsr_pkg::ADDR_W-1:0] phys;
        logic [bsr_pkg::ADDR_W-1:0] bus;
        logic [bsr_pkg::ADDR_W-1:0] routes [$];
        w = '0;
        rnd = $urandom;
        w.address = rnd[bsr_pkg::ADDR_W-1:0];
        rnd = $urandom;
        w.write_data = rnd[bsr_pkg::DATA_W-1:0];
        rnd = $urandom;
        w.map_start = rnd[bsr_pkg::ADDR_W-1:0];
        rnd = $urandom;
        w.map_end = rnd[bsr_pkg::ADDR_W-1:0];
        ofs_val = int'($urandom_range(0, 131070)) - 65535;
        w.map_offset = ofs_val[bsr_pkg::OFS_W-1:0];
        w.op = bsr_pkg::OP_WRITE;
        kind = $urandom_range(0, 99);
        if (kind < 42)
        begin
            if (recent_phys.size() > 0)
            begin
                phys = recent_phys[$urandom_range(0, recent_phys.size() - 1)];
                for (int b = 0; b < NUM_BLOCKS; b++)
                begin
                    bus = phys - shadow_ofs[b][15:0];
                    if (int'(bus[15:12]) == b)
                        routes = {routes, bus};
                end
                if (routes.size() > 0)
                begin
                    w.op = bsr_pkg::OP_READ;
                    w.address = routes[$urandom_range(0, routes.size() - 1)];
                end
            end
        end
        else if (kind < 87)
        begin
            if ($urandom_range(0, 2) == 0 && recent_phys.size() > 0)
            begin
                rnd = $urandom_range(0, 7);
                w.address = recent_phys[$urandom_range(0, recent_phys.size() - 1)]
                            + rnd[bsr_pkg::ADDR_W-1:0];
            end
        end
        else if (kind < 96)
        begin
            w.op = bsr_pkg::OP_MAP;
            case ($urandom_range(0, 3))
                0:
                begin
                    rnd = $urandom_range(0, 3) << 12;
                    w.map_end = w.map_start + rnd[bsr_pkg::ADDR_W-1:0];
                end
                1: w.map_end = w.map_start;
                default: ;
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                ofs_val = int'($urandom_range(0, 64)) - 32;
                w.map_offset = ofs_val[bsr_pkg::OFS_W-1:0];
            end
        end
        else
            w.op = OP_UNUSED;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && read_valid)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: read_data %02h returned with no read pending", $time, read_data);
                fail_count++;
            end
            else
            begin
                expected_byte = pending_reads.pop_front();
                if (read_data !== expected_byte)
                begin
                    $display("%0t: read_data mismatch, expected %02h, got %02h",
                             $time, expected_byte, read_data);
                    fail_count++;
                end
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles, %0d reads still pending",
                     $time, cycle_count, pending_reads.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        ram_word_t w;
        int unsigned sent;
        bit burst;
        bit paused;
        sent = 0;
        burst = 1'b0;
        paused = 1'b0;
        for (int i = 0; i < NUM_BLOCKS; i++)
            shadow_ofs[i] = '0;

        add_row(word_row(bsr_pkg::OP_WRITE, 16'h0000, 8'hA5, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_READ, 16'h0000, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b1, 8'hA5));
        add_row(word_row(bsr_pkg::OP_WRITE, 16'hFFFF, 8'h5A, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_READ, 16'hFFFF, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b1, 8'h5A));
        add_row(word_row(bsr_pkg::OP_WRITE, 16'h1234, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_WRITE, 16'h1235, 8'hFF, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_READ, 16'h1234, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b1, 8'h00));
        add_row(word_row(bsr_pkg::OP_READ, 16'h1235, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b1, 8'hFF));
        add_row(word_row(bsr_pkg::OP_MAP, 16'h0, 8'h00, 16'h1000, 16'h1FFF, 17'h00001,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_READ, 16'h1234, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_MAP, 16'h0, 8'h00, 16'h3000, 16'h2FFF, 17'h07777,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_WRITE, 16'h2FFF, 8'h42, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_READ, 16'h2FFF, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b1, 8'h42));
        add_row(word_row(bsr_pkg::OP_MAP, 16'h0, 8'h00, 16'hF000, 16'hFFFF, 17'h00010,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_READ, 16'hFFF0, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_MAP, 16'h0, 8'h00, 16'h0000, 16'h0FFF, 17'h10001,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_WRITE, 16'h0000, 8'h3C, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_READ, 16'h0000, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_MAP, 16'h0, 8'h00, 16'h2000, 16'h2FFF, 17'h0FFFF,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_WRITE, 16'h2000, 8'h81, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_READ, 16'h1FFE, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_MAP, 16'h0, 8'h00, 16'h0000, 16'hFFFF, 17'h00000,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_READ, 16'h1FFF, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));
        add_row(word_row(bsr_pkg::OP_READ, 16'h0001, 8'h00, 16'h0, 16'h0, 17'h0,
                         1'b0, 8'h00));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i])
        begin
            send_word(directed_words[i]);
            idle_cycles(($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 15)) : 0);
        end

        while (sent < RANDOM_WORDS)
        begin
            if (sent % 150 == 0)
                burst = ($urandom_range(0, 1) == 1);
            make_random_word(w);
            send_word(w);
            sent++;
            if (!paused && sent >= RANDOM_WORDS / 2)
            begin
                paused = 1'b1;
                start <= 1'b0;
                @(posedge clk);
                while (pending_reads.size() != 0)
                    @(posedge clk);
            end
            else
                idle_cycles(burst ? 0 : int'($urandom_range(0, 15)));
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d reads, %0d writes, %0d maps (%0d with start block above end block)",
                 n_reads, n_writes, n_maps, n_empty_maps);
        $display("and %0d unused-op words; %0d returned bytes were compared.",
                 n_unused, n_checked);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
